// ----- sv/tstt_pkg.sv -----
// Package for the time-sorted track table: depth constants, codes, word types.
// No dependencies.
`timescale 1ns / 1ps
package tstt_pkg;

  localparam int unsigned Depth  = 256;
  localparam int unsigned IdxW   = $clog2(Depth);
  localparam int unsigned CntW   = IdxW + 1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_TAKE   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_BADPOS   = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [63:0] start_time;
    logic [63:0]        id_high;
    logic [63:0]        id_low;
    logic [7:0]         position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         where_at;
    logic signed [63:0] taken_time;
    logic [63:0]        taken_id_high;
    logic [63:0]        taken_id_low;
    logic [8:0]         entry_count;
    logic               is_empty;
  } out_word_t;

  // One table or map record: time and id.
  typedef struct packed {
    logic [63:0] t;
    logic [63:0] hi;
    logic [63:0] lo;
  } key_t;

  // True when key a sorts strictly before key b (newer time, then larger id).
  function automatic logic key_before(key_t a, key_t b);
    logic [63:0] sa;
    logic [63:0] sb;
    sa = a.t ^ 64'h8000_0000_0000_0000;
    sb = b.t ^ 64'h8000_0000_0000_0000;
    if (sa != sb) return sa > sb;
    if (a.hi != b.hi) return a.hi > b.hi;
    return a.lo > b.lo;
  endfunction

endpackage

// ----- sv/time_sorted_track_table.sv -----
// Time-sorted track table: a sorted key memory and an id-to-time map memory,
// driven by one sequencer. Depends on tstt_pkg.
`timescale 1ns / 1ps
// One word at a time. Lookup scans all 256 map slots and binary-searches
// the table (up to 9 probes, each a read state then a compare state).
// Insert binary-searches, shifts entries down one read/write per cycle (up
// to 255 entries), then scans the map. Take shifts entries up (up to 255)
// then scans the map. Clear empties the table and the map. Each memory has
// a single read port. The result sits in an output register and the next
// word is taken once it has been handed off.
module time_sorted_track_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tstt_pkg::in_word_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tstt_pkg::out_word_t out_data_o
);
  import tstt_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_BSRD  = 11'b000_0000_0010,
    S_BSCMP = 11'b000_0000_0100,
    S_SHRD  = 11'b000_0000_1000,
    S_SHWR  = 11'b000_0001_0000,
    S_MSCAN = 11'b000_0010_0000,
    S_MFIN  = 11'b000_0100_0000,
    S_LCHK  = 11'b000_1000_0000,
    S_TRD   = 11'b001_0000_0000,
    S_TCAP  = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Memories
  key_t        tab_mem [Depth];
  key_t        map_mem [Depth];
  logic [Depth-1:0] map_vld_q;

  logic        tab_we, map_we;
  logic [IdxW-1:0] tab_waddr, tab_raddr, map_waddr, map_raddr;
  key_t        tab_wdata, map_wdata;
  key_t        tab_rdata_q, map_rdata_q;

  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
    tab_rdata_q <= tab_mem[tab_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_rdata_q <= map_mem[map_raddr];
  end

  // Working registers
  action_e    act_q;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d;     // search bounds / shift index
  logic [CntW-1:0] mid_q, mid_d;
  logic [CntW-1:0] scan_q, scan_d;             // map scan index (one past last read)
  logic        hit_q, hit_d;                   // map match found
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic        free_q, free_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  key_t        key_q, key_d;                   // search / map key
  logic        lk_q, lk_d;                     // lookup search pending
  out_word_t   res_q, res_d;
  logic        ovld_q, ovld_d;
  logic [Depth-1:0] map_vld_d;

  key_t   tab_key;
  logic [IdxW-1:0] scan_prev;
  logic   go_left;

  assign tab_key   = tab_rdata_q;
  assign scan_prev = IdxW'(scan_q - 1'b1);

  assign in_ready_o  = (state_q == S_IDLE) && !ovld_q;
  assign out_valid_o = ovld_q;
  assign out_data_o  = res_q;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    scan_d     = scan_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    key_d      = key_q;
    lk_d       = lk_q;
    res_d      = res_q;
    ovld_d     = ovld_q;
    map_vld_d  = map_vld_q;
    tab_we     = 1'b0;
    tab_waddr  = '0;
    tab_wdata  = key_q;
    tab_raddr  = mid_q[IdxW-1:0];
    map_we     = 1'b0;
    map_waddr  = hit_idx_q;
    map_wdata  = key_q;
    map_raddr  = scan_q[IdxW-1:0];
    go_left    = 1'b0;

    if (ovld_q && out_ready_i) ovld_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !ovld_q) begin
          res_d = '0;
          unique case (action_e'(in_data_i.action))
            ACT_INSERT: begin
              if (fill_q >= CntW'(Depth)) begin
                res_d.status = ST_FULL;
                state_d = S_DONE;
              end else begin
                lo_d = '0; hi_d = fill_q; lk_d = 1'b0;
                key_d = '{t: in_data_i.start_time, hi: in_data_i.id_high,
                          lo: in_data_i.id_low};
                state_d = S_BSRD;
              end
            end
            ACT_LOOKUP: begin
              key_d = '{t: '0, hi: in_data_i.id_high, lo: in_data_i.id_low};
              scan_d = '0; hit_d = 1'b0; free_d = 1'b0;
              state_d = S_MSCAN;
            end
            ACT_TAKE: begin
              if ({1'b0, in_data_i.position} >= fill_q) begin
                res_d.status = ST_BADPOS;
                state_d = S_DONE;
              end else begin
                mid_d = {1'b0, in_data_i.position};
                state_d = S_TRD;
              end
            end
            default: begin
              fill_d = '0;
              map_vld_d = '0;
              state_d = S_DONE;
            end
          endcase
        end
      end
      // Binary search: read mid, compare next cycle
      S_BSRD: begin
        if (lo_q < hi_q) begin
          mid_d = lo_q + ((hi_q - lo_q) >> 1);
          tab_raddr = mid_d[IdxW-1:0];
          state_d = S_BSCMP;
        end else if (lk_q) begin
          tab_raddr = lo_q[IdxW-1:0];
          state_d = S_LCHK;
        end else begin
          // insert: shift from fill down to lo
          hi_d = fill_q;
          tab_raddr = IdxW'(fill_q - 1'b1);
          state_d = (fill_q > lo_q) ? S_SHWR : S_SHRD;
        end
      end
      S_BSCMP: begin
        if (lk_q) go_left = !key_before(tab_key, key_q);
        else      go_left = key_before(key_q, tab_key);
        if (go_left) hi_d = mid_q;
        else         lo_d = mid_q + 1'b1;
        state_d = S_BSRD;
      end
      // Insert shift: hi_q is destination; data for hi_q-1 is in rdata
      S_SHWR: begin
        tab_we = 1'b1;
        tab_waddr = hi_q[IdxW-1:0];
        tab_wdata = tab_key;
        hi_d = hi_q - 1'b1;
        tab_raddr = IdxW'(hi_q - 2'd2);
        if (hi_d == lo_q) state_d = S_SHRD;
      end
      // Write new key at lo, start map scan
      S_SHRD: begin
        tab_we = 1'b1;
        tab_waddr = lo_q[IdxW-1:0];
        tab_wdata = key_q;
        fill_d = fill_q + 1'b1;
        res_d.where_at = lo_q[7:0];
        scan_d = '0; hit_d = 1'b0; free_d = 1'b0;
        state_d = S_MSCAN;
      end
      // Map scan: read slot scan_q, check slot scan_q-1
      S_MSCAN: begin
        map_raddr = scan_q[IdxW-1:0];
        if (scan_q != '0) begin
          if (map_vld_q[scan_prev] && !hit_q && map_rdata_q.hi == key_q.hi &&
              map_rdata_q.lo == key_q.lo) begin
            hit_d = 1'b1; hit_idx_d = scan_prev;
            key_d.t = (act_q == ACT_LOOKUP) ? map_rdata_q.t : key_q.t;
          end
          if (!map_vld_q[scan_prev] && !free_q) begin
            free_d = 1'b1; free_idx_d = scan_prev;
          end
        end
        scan_d = scan_q + 1'b1;
        if (scan_q == CntW'(Depth)) state_d = S_MFIN;
      end
      S_MFIN: begin
        unique case (act_q)
          ACT_INSERT: begin
            if (hit_q || free_q) begin
              map_we = 1'b1;
              map_waddr = hit_q ? hit_idx_q : free_idx_q;
              map_wdata = key_q;
              map_vld_d[map_waddr] = 1'b1;
            end
            state_d = S_DONE;
          end
          ACT_TAKE: begin
            if (hit_q) map_vld_d[hit_idx_q] = 1'b0;
            state_d = S_DONE;
          end
          ACT_LOOKUP: begin
            if (!hit_q) begin
              res_d.status = ST_NOTFOUND;
              state_d = S_DONE;
            end else begin
              lo_d = '0; hi_d = fill_q; lk_d = 1'b1;
              state_d = S_BSRD;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_LCHK: begin
        if (lo_q < fill_q && tab_key.hi == key_q.hi && tab_key.lo == key_q.lo)
          res_d.where_at = lo_q[7:0];
        else
          res_d.status = ST_NOTFOUND;
        state_d = S_DONE;
      end
      // Take: read mid (next entry read ahead), capture, shift up
      S_TRD: begin
        tab_raddr = mid_q[IdxW-1:0];
        state_d = S_TCAP;
        hi_d = '0;
      end
      S_TCAP: begin
        // hi_q==0: first cycle, rdata holds removed entry
        if (hi_q == '0) begin
          res_d.taken_time    = tab_key.t;
          res_d.taken_id_high = tab_key.hi;
          res_d.taken_id_low  = tab_key.lo;
          key_d = tab_key;
          hi_d = CntW'(1);
        end else begin
          tab_we = 1'b1;
          tab_waddr = mid_q[IdxW-1:0];
          tab_wdata = tab_key;
          mid_d = mid_q + 1'b1;
        end
        tab_raddr = IdxW'(mid_d + 1'b1);
        if (mid_d + 1'b1 >= fill_q) begin
          fill_d = fill_q - 1'b1;
          scan_d = '0; hit_d = 1'b0; free_d = 1'b0;
          state_d = S_MSCAN;
        end
      end
      S_DONE: begin
        res_d.entry_count = fill_q;
        res_d.is_empty = (fill_q == '0);
        ovld_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) act_q <= action_e'(in_data_i.action);
    lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d; scan_q <= scan_d;
    hit_idx_q <= hit_idx_d; free_idx_q <= free_idx_d;
    key_q <= key_d; res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      ovld_q    <= 1'b0;
      map_vld_q <= '0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      lk_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      ovld_q    <= ovld_d;
      map_vld_q <= map_vld_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      lk_q      <= lk_d;
    end
  end

endmodule

// ----- sim/tb_time_sorted_track_table.sv -----
// Self-checking testbench for the time-sorted track table.
// Depends on tstt_pkg and time_sorted_track_table.
`timescale 1ns / 1ps
module tb_time_sorted_track_table;
  import tstt_pkg::*;

  localparam int unsigned TblDepth = 256;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;

  time_sorted_track_table DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the sorted table and the id map
  logic [63:0] trk_time [TblDepth];
  logic [63:0] trk_hi   [TblDepth];
  logic [63:0] trk_lo   [TblDepth];
  int unsigned trk_fill;
  bit          slot_used [TblDepth];
  logic [63:0] slot_hi   [TblDepth];
  logic [63:0] slot_lo   [TblDepth];
  logic [63:0] slot_time [TblDepth];

  out_word_t pending_results [$];
  int        fail_count;
  int        words_sent;
  int        words_checked;
  bit        quiet;   // no idling on either side while set

  // Newer time first, then the larger id
  function automatic bit sorts_ahead(logic [63:0] ta, logic [63:0] ha, logic [63:0] la,
                                     logic [63:0] tb, logic [63:0] hb, logic [63:0] lb);
    if (ta != tb) return $signed(ta) > $signed(tb);
    if (ha != hb) return ha > hb;
    return la > lb;
  endfunction

  function automatic int find_slot(logic [63:0] hi, logic [63:0] lo);
    for (int i = 0; i < TblDepth; i++)
      if (slot_used[i] && slot_hi[i] == hi && slot_lo[i] == lo) return i;
    return -1;
  endfunction

  // Apply one word to the shadow state and return the expected result
  function automatic out_word_t apply_track_op(in_word_t w);
    out_word_t r;
    int unsigned lo_b;
    int unsigned hi_b;
    int unsigned mid;
    int slot;
    r = '0;
    case (action_e'(w.action))
      ACT_INSERT: begin
        if (trk_fill >= TblDepth) begin
          r.status = ST_FULL;
        end else begin
          lo_b = 0;
          hi_b = trk_fill;
          while (lo_b < hi_b) begin
            mid = lo_b + (hi_b - lo_b) / 2;
            if (sorts_ahead(w.start_time, w.id_high, w.id_low,
                            trk_time[mid], trk_hi[mid], trk_lo[mid])) hi_b = mid;
            else lo_b = mid + 1;
          end
          for (int i = trk_fill; i > lo_b; i--) begin
            trk_time[i] = trk_time[i-1];
            trk_hi[i]   = trk_hi[i-1];
            trk_lo[i]   = trk_lo[i-1];
          end
          trk_time[lo_b] = w.start_time;
          trk_hi[lo_b]   = w.id_high;
          trk_lo[lo_b]   = w.id_low;
          trk_fill++;
          slot = find_slot(w.id_high, w.id_low);
          if (slot < 0)
            for (int i = 0; i < TblDepth; i++)
              if (!slot_used[i]) begin
                slot = i;
                break;
              end
          if (slot >= 0) begin
            slot_used[slot] = 1'b1;
            slot_hi[slot]   = w.id_high;
            slot_lo[slot]   = w.id_low;
            slot_time[slot] = w.start_time;
          end
          r.where_at = lo_b[7:0];
        end
      end
      ACT_LOOKUP: begin
        slot = find_slot(w.id_high, w.id_low);
        if (slot < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          lo_b = 0;
          hi_b = trk_fill;
          while (lo_b < hi_b) begin
            mid = lo_b + (hi_b - lo_b) / 2;
            if (sorts_ahead(trk_time[mid], trk_hi[mid], trk_lo[mid],
                            slot_time[slot], w.id_high, w.id_low)) lo_b = mid + 1;
            else hi_b = mid;
          end
          if (lo_b < trk_fill && trk_hi[lo_b] == w.id_high && trk_lo[lo_b] == w.id_low)
            r.where_at = lo_b[7:0];
          else
            r.status = ST_NOTFOUND;
        end
      end
      ACT_TAKE: begin
        if (w.position >= trk_fill) begin
          r.status = ST_BADPOS;
        end else begin
          r.taken_time    = trk_time[w.position];
          r.taken_id_high = trk_hi[w.position];
          r.taken_id_low  = trk_lo[w.position];
          for (int i = w.position; i + 1 < trk_fill; i++) begin
            trk_time[i] = trk_time[i+1];
            trk_hi[i]   = trk_hi[i+1];
            trk_lo[i]   = trk_lo[i+1];
          end
          trk_fill--;
          slot = find_slot(r.taken_id_high, r.taken_id_low);
          if (slot >= 0) slot_used[slot] = 1'b0;
        end
      end
      default: begin
        trk_fill = 0;
        for (int i = 0; i < TblDepth; i++) slot_used[i] = 1'b0;
      end
    endcase
    r.entry_count = trk_fill[8:0];
    r.is_empty    = (trk_fill == 0);
    return r;
  endfunction

  // Send one word, predict at acceptance, then maybe idle
  task automatic send_word(in_word_t w);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(apply_track_op(w));
    words_sent++;
    if (!quiet && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic send_op(action_e a, logic [63:0] t, logic [63:0] hi, logic [63:0] lo,
                         logic [7:0] p);
    in_word_t w;
    w.action     = a;
    w.start_time = t;
    w.id_high    = hi;
    w.id_low     = lo;
    w.position   = p;
    send_word(w);
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH word %0d %s: got %h want %h", words_checked, field, got, want);
    fail_count++;
  endtask

  // Output side: random back-pressure and field-by-field compare
  always @(posedge clk_i) begin
    out_word_t want;
    out_ready_i <= quiet || ($urandom_range(99) >= 9);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("MISMATCH unexpected result word");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status != want.status)
          report_mismatch("status", out_data_o.status, want.status);
        if (out_data_o.where_at != want.where_at)
          report_mismatch("where_at", out_data_o.where_at, want.where_at);
        if (out_data_o.taken_time != want.taken_time)
          report_mismatch("taken_time", out_data_o.taken_time, want.taken_time);
        if (out_data_o.taken_id_high != want.taken_id_high)
          report_mismatch("taken_id_high", out_data_o.taken_id_high, want.taken_id_high);
        if (out_data_o.taken_id_low != want.taken_id_low)
          report_mismatch("taken_id_low", out_data_o.taken_id_low, want.taken_id_low);
        if (out_data_o.entry_count != want.entry_count)
          report_mismatch("entry_count", out_data_o.entry_count, want.entry_count);
        if (out_data_o.is_empty != want.is_empty)
          report_mismatch("is_empty", out_data_o.is_empty, want.is_empty);
        words_checked++;
      end
    end
  end

  // Random field helpers: mostly a small pool so keys collide and lookups hit
  function automatic logic [63:0] pick_time();
    case ($urandom_range(9))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return {$urandom, $urandom};
      default: return 64'($signed($urandom_range(8)) - 4);
    endcase
  endfunction

  function automatic logic [63:0] pick_id_part(int span);
    case ($urandom_range(9))
      0: return '1;
      1: return {$urandom, $urandom};
      default: return 64'($urandom_range(span));
    endcase
  endfunction

  function automatic logic [7:0] pick_pos();
    if (trk_fill > 0 && $urandom_range(9) < 8) return 8'($urandom_range(trk_fill - 1));
    return 8'($urandom);
  endfunction

  task automatic random_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 42)      send_op(ACT_INSERT, pick_time(), pick_id_part(2), pick_id_part(4), 8'($urandom));
    else if (r < 72) send_op(ACT_LOOKUP, pick_time(), pick_id_part(2), pick_id_part(4), 8'($urandom));
    else if (r < 98) send_op(ACT_TAKE, pick_time(), pick_id_part(2), pick_id_part(4), pick_pos());
    else             send_op(ACT_CLEAR, pick_time(), pick_id_part(2), pick_id_part(4), 8'($urandom));
  endtask

  // Empty table cases, extreme keys, ties, duplicate ids, bad positions
  task automatic test_directed();
    send_op(ACT_LOOKUP, 0, 0, 0, 0);
    send_op(ACT_TAKE, 0, 0, 0, 0);
    send_op(ACT_INSERT, 64'h8000_0000_0000_0000, 0, 0, 8'hff);
    send_op(ACT_INSERT, 64'h7fff_ffff_ffff_ffff, '1, '1, 0);
    send_op(ACT_INSERT, 0, 5, 1, 0);
    send_op(ACT_INSERT, 0, 5, 1, 0);            // equal key goes after the first
    send_op(ACT_INSERT, 0, 5, 2, 0);            // same time, larger id goes ahead
    send_op(ACT_INSERT, 0, 4, '1, 0);
    send_op(ACT_LOOKUP, 0, 5, 1, 0);
    send_op(ACT_LOOKUP, 0, '1, '1, 0);
    send_op(ACT_LOOKUP, 0, 0, 0, 0);
    send_op(ACT_LOOKUP, 0, 9, 9, 0);
    send_op(ACT_INSERT, 64'd7, 5, 1, 0);        // duplicate id remaps its time
    send_op(ACT_LOOKUP, 0, 5, 1, 0);
    send_op(ACT_TAKE, 0, 0, 0, 8'd0);           // takes the entry with the newest time
    send_op(ACT_LOOKUP, 0, 5, 1, 0);            // duplicate id still found at its new time
    send_op(ACT_TAKE, 0, 0, 0, 8'hff);
    send_op(ACT_TAKE, 0, 0, 0, 8'd6);
    send_op(ACT_TAKE, 0, 0, 0, 8'd5);
    send_op(ACT_TAKE, 0, 0, 0, 8'd2);
    send_op(ACT_CLEAR, '1, '1, '1, 8'hff);
    send_op(ACT_LOOKUP, 0, '1, '1, 0);
    send_op(ACT_TAKE, 0, 0, 0, 0);
  endtask

  task automatic test_random(int count);
    repeat (count) random_word();
  endtask

  // Fill the table to the top with no idling, then full-table inserts and takes
  task automatic test_full_table();
    quiet = 1'b1;
    send_op(ACT_CLEAR, 0, 0, 0, 0);
    while (trk_fill < TblDepth)
      send_op(ACT_INSERT, pick_time(), pick_id_part(40), pick_id_part(4), 0);
    quiet = 1'b0;
    send_op(ACT_INSERT, 0, 1, 1, 0);
    send_op(ACT_INSERT, 64'h7fff_ffff_ffff_ffff, '1, '1, 0);
    send_op(ACT_TAKE, 0, 0, 0, 8'd255);
    send_op(ACT_TAKE, 0, 0, 0, 8'd0);
    send_op(ACT_INSERT, 64'h8000_0000_0000_0000, 0, 0, 0);
    repeat (20) random_word();
  endtask

  initial begin
    fail_count = 0;
    words_sent = 0;
    words_checked = 0;
    quiet = 1'b0;
    trk_fill = 0;
    for (int i = 0; i < TblDepth; i++) slot_used[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300);
    test_full_table();
    test_random(250);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    $display("Sent %0d words, checked %0d results: inserts, lookups, takes, clears,",
             words_sent, words_checked);
    $display("including a full table, extreme keys, ties and duplicate ids.");
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #100ms;
    $display("Timeout waiting for handshakes");
    $display("Test completed with failures");
    $finish;
  end

endmodule
